// ===== design/cpwq_pkg.sv =====
// Package for the coalescing priority work queue.
// Holds the queue geometry, the work item type, request and status codes
// and the control types shared by the controller and the datapath.
`timescale 1ns / 1ps

package cpwq_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 8;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	// One queued work item.
	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  object;
		logic [7:0]  param;
		logic [31:0] arg;
		logic        user;
	} work_t;

	// Request codes; the fourth code is unused.
	typedef enum logic [1:0] {
		REQ_ENQUEUE = 2'd0,
		REQ_POP     = 2'd1,
		REQ_CLEAR   = 2'd2
	} req_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_COALESCED = 3'd1,
		ST_REJECTED  = 3'd2,
		ST_POPPED    = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_CLEARED   = 3'd5
	} stat_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_blocked;
	} dp_sts_t;

endpackage

// ===== design/cpwq_req_if.sv =====
// Request channel interface of the coalescing priority work queue.
// Carries valid, ready and the request payload; no dependencies.
`timescale 1ns / 1ps

interface cpwq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [2:0]  item_kind;
	logic [4:0]  item_object;
	logic [7:0]  item_param;
	logic [31:0] item_arg;
	logic        item_user;
	logic        active_valid;
	logic [2:0]  active_kind;
	logic [4:0]  active_object;
	logic [7:0]  active_param;
	logic [31:0] active_arg;
	logic        active_user;

	modport source (
		output valid, req_type, item_kind, item_object, item_param, item_arg, item_user,
		output active_valid, active_kind, active_object, active_param, active_arg,
		output active_user,
		input  ready
	);

	modport sink (
		input  valid, req_type, item_kind, item_object, item_param, item_arg, item_user,
		input  active_valid, active_kind, active_object, active_param, active_arg,
		input  active_user,
		output ready
	);
endinterface

// ===== design/cpwq_rsp_if.sv =====
// Result channel interface of the coalescing priority work queue.
// Carries valid, ready and the result payload; no dependencies.
`timescale 1ns / 1ps

interface cpwq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  out_kind;
	logic [4:0]  out_object;
	logic [7:0]  out_param;
	logic [31:0] out_arg;
	logic        out_user;
	logic [3:0]  entry_count;

	modport source (
		output valid, status, out_kind, out_object, out_param, out_arg, out_user,
		output entry_count,
		input  ready
	);

	modport sink (
		input  valid, status, out_kind, out_object, out_param, out_arg, out_user,
		input  entry_count,
		output ready
	);
endinterface

// ===== design/cpwq_ctrl.sv =====
// Controller of the coalescing priority work queue.
// Sequences capture, scan and commit of one request; uses cpwq_pkg.
`timescale 1ns / 1ps

module cpwq_ctrl
	import cpwq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_sts_t  sts,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: scan, then commit once the result register is free.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (!sts.out_blocked) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs to the channel and the datapath.
	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_COMMIT: begin
				cmd.commit = !sts.out_blocked;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/cpwq_datapath.sv =====
// Datapath of the coalescing priority work queue: entry registers, match and
// search logic, the shift-and-append update and the result register.
// Uses cpwq_pkg and the result channel interface cpwq_rsp_if.
`timescale 1ns / 1ps

module cpwq_datapath
	import cpwq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output dp_sts_t     sts,
	input  logic [1:0]  in_req_type,
	input  work_t       in_item,
	input  logic        in_act_valid,
	input  work_t       in_act,
	cpwq_rsp_if.source  rsp
);

	// Captured request.
	logic [1:0] req_type_q;
	work_t      item_q;
	logic       act_valid_q;
	work_t      act_q;

	// Queue storage, oldest entry at index zero.
	work_t            entries_q [QUEUE_DEPTH];
	logic [CNT_W-1:0] count_q;

	// Scan results.
	logic             dup_q;
	logic             evict_ok_q;
	logic [IDX_W-1:0] evict_pos_q;
	logic [IDX_W-1:0] pop_pos_q;

	// Result register.
	logic             out_valid_q;
	logic [2:0]       status_q;
	work_t            out_item_q;
	logic [3:0]       out_count_q;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q  <= in_req_type;
			item_q      <= in_item;
			act_valid_q <= in_act_valid;
			act_q       <= in_act;
		end
	end

	// Scan: duplicate check, newest background entry, oldest user entry (else index zero).
	logic             dup_d;
	logic             evict_ok_d;
	logic [IDX_W-1:0] evict_pos_d;
	logic [IDX_W-1:0] pop_pos_d;

	always_comb begin
		dup_d       = act_valid_q && (act_q == item_q);
		evict_ok_d  = 1'b0;
		evict_pos_d = '0;
		pop_pos_d   = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if ((CNT_W'(i) < count_q) && (entries_q[i] == item_q)) dup_d = 1'b1;
			if (!entries_q[i].user) begin
				evict_ok_d  = 1'b1;
				evict_pos_d = IDX_W'(i);
			end
		end
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < count_q) && entries_q[i].user) pop_pos_d = IDX_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			dup_q       <= dup_d;
			evict_ok_q  <= evict_ok_d;
			evict_pos_q <= evict_pos_d;
			pop_pos_q   <= pop_pos_d;
		end
	end

	// Commit decision from the request code and the scan results.
	logic             full;
	logic             rm;
	logic [IDX_W-1:0] rm_pos;
	logic             app;
	logic             clr;
	logic [2:0]       status_d;
	work_t            pop_item;
	logic [CNT_W-1:0] count_rm;
	logic [CNT_W-1:0] count_d;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		rm       = 1'b0;
		rm_pos   = '0;
		app      = 1'b0;
		clr      = 1'b0;
		status_d = ST_REJECTED;
		pop_item = '0;
		unique case (req_type_q)
			REQ_ENQUEUE: begin
				if (dup_q) begin
					status_d = ST_COALESCED;
				end else if (!full) begin
					app      = 1'b1;
					status_d = ST_ACCEPTED;
				end else if (item_q.user && evict_ok_q) begin
					rm       = 1'b1;
					rm_pos   = evict_pos_q;
					app      = 1'b1;
					status_d = ST_ACCEPTED;
				end
			end
			REQ_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					rm       = 1'b1;
					rm_pos   = pop_pos_q;
					pop_item = entries_q[pop_pos_q];
					status_d = ST_POPPED;
				end
			end
			REQ_CLEAR: begin
				clr      = 1'b1;
				status_d = ST_CLEARED;
			end
			default: begin
				status_d = ST_REJECTED;
			end
		endcase
	end

	assign count_rm = count_q - CNT_W'(rm);
	assign count_d  = clr ? '0 : (count_rm + CNT_W'(app));

	// Each entry's upper neighbor; the top entry has none and keeps itself.
	work_t upper [QUEUE_DEPTH];
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_upper
		if (g < QUEUE_DEPTH - 1) begin : g_shift
			assign upper[g] = entries_q[g + 1];
		end else begin : g_top
			assign upper[g] = entries_q[g];
		end
	end

	// Entry update: close the gap at the removed slot, then append.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (app && (CNT_W'(i) == count_rm)) begin
					entries_q[i] <= item_q;
				end else if (rm && (IDX_W'(i) >= rm_pos)) begin
					entries_q[i] <= upper[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	// Result register; the count is reported modulo sixteen.
	logic [CNT_W+3:0] count_ext;
	assign count_ext = {4'b0000, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q    <= status_d;
			out_item_q  <= pop_item;
			out_count_q <= count_ext[3:0];
		end
	end

	assign sts.out_blocked = out_valid_q && !rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.out_kind    = out_item_q.kind;
	assign rsp.out_object  = out_item_q.object;
	assign rsp.out_param   = out_item_q.param;
	assign rsp.out_arg     = out_item_q.arg;
	assign rsp.out_user    = out_item_q.user;
	assign rsp.entry_count = out_count_q;

endmodule

// ===== design/coalescing_priority_work_queue.sv =====
// A bounded queue of up to QUEUE_DEPTH work items that merges duplicate
// enqueues and serves user-initiated items ahead of background ones. Every
// request (enqueue, pop or clear) gives exactly one result. A request is taken
// when the block is idle and occupies it through capture, a scan in which all
// entries are compared against the new item in parallel and the evict and pop
// positions are found, and a commit that shifts the entries and loads the
// result register. The next request is accepted while a result still waits in
// that register; commit waits only if it is still occupied. After reset the
// queue is empty and usable at once.
// Uses cpwq_pkg, cpwq_req_if, cpwq_rsp_if, cpwq_ctrl and cpwq_datapath.
`timescale 1ns / 1ps

module coalescing_priority_work_queue
	import cpwq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	cpwq_req_if.sink   req,
	cpwq_rsp_if.source rsp
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;
	logic     in_ready;
	work_t    in_item;
	work_t    in_act;

	assign req.ready = in_ready;

	// Gather the channel fields into work items.
	assign in_item = '{kind: req.item_kind, object: req.item_object,
		param: req.item_param, arg: req.item_arg, user: req.item_user};
	assign in_act  = '{kind: req.active_kind, object: req.active_object,
		param: req.active_param, arg: req.active_arg, user: req.active_user};

	cpwq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpwq_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_req_type  (req.req_type),
		.in_item      (in_item),
		.in_act_valid (req.active_valid),
		.in_act       (in_act),
		.rsp          (rsp)
	);

endmodule

// ===== design/cpwq_checker.sv =====
// Port-level checks for the coalescing priority work queue and the bind that
// attaches them to the top level. Uses cpwq_pkg.
`timescale 1ns / 1ps

module cpwq_checker
	import cpwq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [2:0]  rsp_out_kind,
	input logic [4:0]  rsp_out_object,
	input logic [7:0]  rsp_out_param,
	input logic [31:0] rsp_out_arg,
	input logic        rsp_out_user,
	input logic [3:0]  rsp_entry_count
);

	// A result is held until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("result dropped or changed before transfer");

	// The block works on one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	// Only a pop carries item fields.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_POPPED) |->
		(rsp_out_kind == '0) && (rsp_out_object == '0) && (rsp_out_param == '0) &&
		(rsp_out_arg == '0) && !rsp_out_user)
		else $error("item fields set on a result that is not a pop");

	// A clear leaves the queue empty.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_CLEARED) |-> (rsp_entry_count == '0))
		else $error("clear reported a nonzero count");

	// The count never exceeds the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (32'(rsp_entry_count) <= QUEUE_DEPTH))
		else $error("count above queue depth");

endmodule

bind coalescing_priority_work_queue cpwq_checker u_cpwq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_out_kind    (rsp.out_kind),
	.rsp_out_object  (rsp.out_object),
	.rsp_out_param   (rsp.out_param),
	.rsp_out_arg     (rsp.out_arg),
	.rsp_out_user    (rsp.out_user),
	.rsp_entry_count (rsp.entry_count)
);
